// ===== sv/lcr_pkg.sv =====
// ----------------------------------------------------------------------------
// lcr_pkg
// Shared types and constants for the load cell serial reader.
// ----------------------------------------------------------------------------
`default_nettype none

package lcr_pkg;

    localparam int RAW_W    = 24;
    localparam int WEIGHT_W = 24;
    localparam int GAIN_W   = 20;
    localparam int TMO_W    = 16;
    localparam int XP_W     = 2;
    localparam int CFG_W    = 24;
    localparam int CFG_IDX_W = 2;
    localparam int PROD_W   = RAW_W + GAIN_W;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT_LIMIT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_EXTRA_PULSES  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ZERO_OFFSET   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_Q16      = 2'd3;

    // reset values
    localparam logic [TMO_W-1:0]         RST_TIMEOUT_LIMIT = 16'd1000;
    localparam logic [XP_W-1:0]          RST_EXTRA_PULSES  = 2'd3;
    localparam logic signed [RAW_W-1:0]  RST_ZERO_OFFSET   = 24'sd285827;
    localparam logic [GAIN_W-1:0]        RST_GAIN_Q16      = 20'd70804;

    typedef struct packed {
        logic start_req;
        logic data_level;
    } t_in_item;

    typedef struct packed {
        logic                       clock_out;
        logic                       busy_res;
        logic                       done_res;
        logic                       timed_out;
        logic signed [RAW_W-1:0]    raw_reading;
        logic [WEIGHT_W-1:0]        weight;
    } t_out_item;

    // one tick's outcome as handed from the sequencer to the arithmetic side
    typedef struct packed {
        logic                       clock_out;
        logic                       busy;
        logic                       done;
        logic                       tmo;
        logic                       need_weight;
        logic signed [RAW_W-1:0]    raw;
    } t_rec;

    typedef struct packed {
        logic [TMO_W-1:0]           timeout_limit;
        logic [XP_W-1:0]            extra_pulses;
        logic signed [RAW_W-1:0]    zero_offset;
        logic [GAIN_W-1:0]          gain_q16;
    } t_cfg;

endpackage

`default_nettype wire

// ===== sv/lcr_queue.sv =====
// ----------------------------------------------------------------------------
// lcr_queue
// Small register FIFO; a write is taken when full if a read happens too.
// ----------------------------------------------------------------------------
`default_nettype none

module lcr_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_wr,
    input  wire logic [WIDTH-1:0] i_wr_data,
    input  wire logic             i_rd,
    output logic      [WIDTH-1:0] o_rd_data,
    output logic                  o_full,
    output logic                  o_empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wr_ptr, r_rd_ptr;
    logic [CW-1:0]    r_count;
    logic             do_wr, do_rd;

    assign o_full    = (r_count == CW'(DEPTH));
    assign o_empty   = (r_count == '0);
    assign o_rd_data = r_mem[r_rd_ptr];
    assign do_rd     = i_rd && !o_empty;
    assign do_wr     = i_wr && (!o_full || do_rd);

    always_ff @(posedge i_clk) begin
        if (do_wr) begin
            r_mem[r_wr_ptr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_wr) begin
                r_wr_ptr <= (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_rd) begin
                r_rd_ptr <= (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            case ({do_wr, do_rd})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== sv/lcr_front.sv =====
// ----------------------------------------------------------------------------
// lcr_front
// Serial sequencer: wait for ready, clock the data bits, send extra pulses.
// ----------------------------------------------------------------------------
`default_nettype none

module lcr_front
    import lcr_pkg::*;
#(
    parameter int DATA_BITS = 24
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_accept,
    input  wire t_in_item i_item,
    input  wire t_cfg     i_cfg,
    output t_rec          o_rec
);

    localparam int BCW  = $clog2(DATA_BITS + 1);
    localparam int KEEP = (DATA_BITS < RAW_W) ? DATA_BITS : RAW_W;

    typedef enum logic [1:0] {PH_IDLE, PH_WAIT, PH_SHIFT, PH_EXTRA} t_phase;

    t_phase                 r_phase, n_phase;
    logic [BCW-1:0]         r_bit_cnt, n_bit_cnt, bc_inc;
    logic [TMO_W-1:0]       r_wait_cnt, n_wait_cnt;
    logic [RAW_W-1:0]       r_shift, n_shift;
    logic                   r_clock, n_clock;
    logic                   done, tmo, finish;
    logic [TMO_W:0]         wait_inc;
    logic [RAW_W-1:0]       raw_ext;

    assign bc_inc   = r_bit_cnt + 1'b1;
    assign wait_inc = {1'b0, r_wait_cnt} + 1'b1;

    always_comb begin
        n_phase    = r_phase;
        n_bit_cnt  = r_bit_cnt;
        n_wait_cnt = r_wait_cnt;
        n_shift    = r_shift;
        n_clock    = r_clock;
        done       = 1'b0;
        tmo        = 1'b0;
        finish     = 1'b0;
        case (r_phase)
            PH_IDLE: begin
                n_clock = 1'b0;
                if (i_item.start_req) begin
                    n_phase    = PH_WAIT;
                    n_wait_cnt = '0;
                end
            end
            PH_WAIT: begin
                if (!i_item.data_level) begin
                    n_phase   = PH_SHIFT;
                    n_bit_cnt = '0;
                    n_shift   = '0;
                    n_clock   = 1'b0;
                end else if (wait_inc >= {1'b0, i_cfg.timeout_limit}) begin
                    n_phase    = PH_IDLE;
                    n_wait_cnt = '0;
                    done       = 1'b1;
                    tmo        = 1'b1;
                end else begin
                    n_wait_cnt = wait_inc[TMO_W-1:0];
                end
            end
            PH_SHIFT: begin
                if (!r_clock) begin
                    n_clock = 1'b1;
                end else begin
                    n_shift   = {r_shift[RAW_W-2:0], i_item.data_level};
                    n_clock   = 1'b0;
                    n_bit_cnt = bc_inc;
                    if (bc_inc >= BCW'(DATA_BITS)) begin
                        n_bit_cnt = '0;
                        if (i_cfg.extra_pulses == '0) begin
                            finish = 1'b1;
                        end else begin
                            n_phase = PH_EXTRA;
                        end
                    end
                end
            end
            PH_EXTRA: begin
                if (!r_clock) begin
                    n_clock = 1'b1;
                end else begin
                    n_clock   = 1'b0;
                    n_bit_cnt = bc_inc;
                    if (bc_inc >= BCW'(i_cfg.extra_pulses)) begin
                        finish = 1'b1;
                    end
                end
            end
            default: begin
                n_phase = PH_IDLE;
            end
        endcase
        if (finish) begin
            done      = 1'b1;
            n_phase   = PH_IDLE;
            n_bit_cnt = '0;
        end
    end

    // keep the low KEEP bits, sign-extended from the top one kept
    always_comb begin
        for (int i = 0; i < RAW_W; i++) begin
            raw_ext[i] = (i < KEEP) ? n_shift[i] : n_shift[KEEP-1];
        end
    end

    always_comb begin
        o_rec.clock_out   = n_clock;
        o_rec.busy        = (n_phase != PH_IDLE);
        o_rec.done        = done;
        o_rec.tmo         = tmo;
        o_rec.need_weight = finish;
        o_rec.raw         = finish ? raw_ext : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_IDLE;
            r_bit_cnt  <= '0;
            r_wait_cnt <= '0;
            r_shift    <= '0;
            r_clock    <= 1'b0;
        end else if (i_accept) begin
            r_phase    <= n_phase;
            r_bit_cnt  <= n_bit_cnt;
            r_wait_cnt <= n_wait_cnt;
            r_shift    <= n_shift;
            r_clock    <= n_clock;
        end
    end

`ifndef SYNTH
    a_clock_only_when_clocking: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clock |-> (r_phase == PH_SHIFT || r_phase == PH_EXTRA))
        else $error("serial clock high outside shift/extra phase");
    a_done_ends_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && o_rec.done) |=> (r_phase == PH_IDLE && !r_clock))
        else $error("read finished but sequencer not idle");
    a_timeout_from_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && o_rec.tmo) |-> (r_phase == PH_WAIT && !o_rec.need_weight))
        else $error("timeout outside the wait phase");
`endif

endmodule

`default_nettype wire

// ===== sv/lcr_back.sv =====
// ----------------------------------------------------------------------------
// lcr_back
// Weight conversion pipeline: offset subtract, gain multiply, scale and clamp.
// ----------------------------------------------------------------------------
`default_nettype none

module lcr_back
    import lcr_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire t_cfg  i_cfg,
    input  wire t_rec  i_rec,
    input  wire logic  i_rec_valid,
    output logic       o_rec_rd,
    input  wire logic  i_pop,
    output t_out_item  o_item,
    output logic       o_empty
);

    localparam int DEPTH_OUT = 4;

    logic                   r_v1, r_v2;
    t_rec                   r_rec1, r_rec2;
    logic [RAW_W-1:0]       r_diff;
    logic [PROD_W-1:0]      r_prod;
    logic signed [RAW_W:0]  diff;
    logic                   pos;
    logic                   advance, oq_full, oq_empty, oq_rd;
    t_out_item              oq_wr_data;
    logic [$bits(t_out_item)-1:0] oq_rd_data;

    assign oq_rd    = i_pop && !oq_empty;
    assign advance  = !oq_full || oq_rd;
    assign o_rec_rd = advance && i_rec_valid;

    // 25-bit difference; only a positive one goes on to the multiplier
    assign diff = {i_rec.raw[RAW_W-1], i_rec.raw}
                - {i_cfg.zero_offset[RAW_W-1], i_cfg.zero_offset};
    assign pos  = i_rec.need_weight && !diff[RAW_W] && (diff != '0);

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_rec1 <= i_rec;
            r_diff <= pos ? diff[RAW_W-1:0] : '0;
            r_rec2 <= r_rec1;
            r_prod <= PROD_W'(r_diff) * PROD_W'(i_cfg.gain_q16);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else if (advance) begin
            r_v1 <= i_rec_valid;
            r_v2 <= r_v1;
        end
    end

    always_comb begin
        oq_wr_data.clock_out   = r_rec2.clock_out;
        oq_wr_data.busy_res    = r_rec2.busy;
        oq_wr_data.done_res    = r_rec2.done;
        oq_wr_data.timed_out   = r_rec2.tmo;
        oq_wr_data.raw_reading = r_rec2.raw;
        oq_wr_data.weight      = (|r_prod[PROD_W-1:WEIGHT_W+16]) ? '1
                                                                 : r_prod[WEIGHT_W+15:16];
    end

    lcr_queue #(
        .WIDTH ($bits(t_out_item)),
        .DEPTH (DEPTH_OUT)
    ) u_out_queue (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (r_v2 && advance),
        .i_wr_data (oq_wr_data),
        .i_rd      (oq_rd),
        .o_rd_data (oq_rd_data),
        .o_full    (oq_full),
        .o_empty   (oq_empty)
    );

    assign o_item  = t_out_item'(oq_rd_data);
    assign o_empty = oq_empty;

`ifndef SYNTH
    a_diff_only_for_reads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v1 && !r_rec1.need_weight) |-> (r_diff == '0))
        else $error("offset difference on a tick without a finished read");
    a_prod_only_for_reads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v2 && !r_rec2.need_weight) |-> (r_prod == '0))
        else $error("gain product on a tick without a finished read");
    a_stall_holds_stage: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!advance && r_v2) |=> (r_v2 && $stable(r_prod)))
        else $error("pipeline moved while the result queue was blocked");
`endif

endmodule

`default_nettype wire

// ===== sv/load_cell_adc_serial_reader.sv =====
// ----------------------------------------------------------------------------
// load_cell_adc_serial_reader
// Two-wire serial reader for a 24-bit load cell converter, with weight output.
// ----------------------------------------------------------------------------
// Throughput: one request per cycle while the queue is not full; the sequencer steps once per request.
// Path: a request's record goes through the queue, the offset subtract stage, the gain
//   multiply stage and the result queue; a full result queue can hold it on the way.
// The gain multiply (24 x 20 bits) sets the stage depth of the back end.
// Reset: synchronous, active low; sequencer idle, both queues empty and the
//   registers back to their defaults in the same cycle. No clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module load_cell_adc_serial_reader
    import lcr_pkg::*;
#(
    parameter int DATA_BITS = 24
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    // request side
    input  wire logic                 push,
    output logic                      full,
    input  wire t_in_item             i_in_item,
    // result side
    output logic                      empty,
    input  wire logic                 pop,
    output t_out_item                 o_out_item,
    // register writes
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [CFG_W-1:0]     i_cfg_data
);

    // Depth of the queue between sequencer and arithmetic. It lets the
    // sequencer keep taking ticks, until four records wait in it, while the result side
    // is held by its consumer.
    localparam int DEPTH_MID = 4;

    t_cfg  r_cfg;
    logic  accept;
    t_rec  front_rec;
    logic  mq_empty, mq_rd;
    logic [$bits(t_rec)-1:0] mq_rd_data;

    // Register file. Writes must land only while the block is quiet; the block itself
    // does not enforce this and has no interlock with the sequencer or the pipeline.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.timeout_limit <= RST_TIMEOUT_LIMIT;
            r_cfg.extra_pulses  <= RST_EXTRA_PULSES;
            r_cfg.zero_offset   <= RST_ZERO_OFFSET;
            r_cfg.gain_q16      <= RST_GAIN_Q16;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_TIMEOUT_LIMIT: r_cfg.timeout_limit <= i_cfg_data[TMO_W-1:0];
                CFG_EXTRA_PULSES:  r_cfg.extra_pulses  <= i_cfg_data[XP_W-1:0];
                CFG_ZERO_OFFSET:   r_cfg.zero_offset   <= i_cfg_data[RAW_W-1:0];
                CFG_GAIN_Q16:      r_cfg.gain_q16      <= i_cfg_data[GAIN_W-1:0];
                default:           r_cfg               <= r_cfg;
            endcase
        end
    end

    // A request is one tick of the serial sequence.
    assign accept = push && !full;

    // Front: sequencer, one step per request, writes its tick record.
    lcr_front #(
        .DATA_BITS (DATA_BITS)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_item   (i_in_item),
        .i_cfg    (r_cfg),
        .o_rec    (front_rec)
    );

    // Decoupling queue: full here is what the request side sees.
    lcr_queue #(
        .WIDTH ($bits(t_rec)),
        .DEPTH (DEPTH_MID)
    ) u_mid_queue (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (accept),
        .i_wr_data (front_rec),
        .i_rd      (mq_rd),
        .o_rd_data (mq_rd_data),
        .o_full    (full),
        .o_empty   (mq_empty)
    );

    // Back: weight arithmetic and the result queue.
    lcr_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_rec       (t_rec'(mq_rd_data)),
        .i_rec_valid (!mq_empty),
        .o_rec_rd    (mq_rd),
        .i_pop       (pop),
        .o_item      (o_out_item),
        .o_empty     (empty)
    );

`ifndef SYNTH
    a_result_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_out_item.done_res) |-> !o_out_item.busy_res)
        else $error("finished read shown as still busy");
    a_timeout_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_out_item.timed_out)
        |-> (o_out_item.done_res && o_out_item.raw_reading == '0
             && o_out_item.weight == '0))
        else $error("timeout result carries data");
    a_idle_fields_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !o_out_item.done_res)
        |-> (o_out_item.raw_reading == '0 && o_out_item.weight == '0
             && !o_out_item.timed_out))
        else $error("data fields set on a tick that is not a finish");
`endif

endmodule

`default_nettype wire
